FILE: design/plcfb_pkg.sv
package plcfb_pkg;

   localparam logic [7:0] STX_CHAR   = 8'h02;
   localparam logic [7:0] ETX_CHAR   = 8'h03;
   localparam logic [7:0] ZERO_CHAR  = 8'h30;
   localparam logic [7:0] ONE_CHAR   = 8'h31;
   localparam logic [7:0] FOUR_CHAR  = 8'h34;
   localparam logic [7:0] ALPHA_BIAS = 8'h37;   // 'A' - 10

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam int unsigned REQ_TDATA_W = 40;
   localparam int unsigned WORD_W      = 13;
   localparam int unsigned COUNT_W     = 4;
   localparam int unsigned VALUE_W     = 16;
   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned STEP_W      = 4;

   // byte position of the last character, read and write frames
   localparam logic [STEP_W-1:0] READ_LAST_STEP  = 4'd10;
   localparam logic [STEP_W-1:0] WRITE_LAST_STEP = 4'd14;

   typedef struct packed {
      logic                    op;
      logic [ADDR_W-1:0]       addr;
      logic [COUNT_W-1:0]      count;
      logic [VALUE_W-1:0]      value;
      logic [STEP_W-1:0]       last_step;
   } frame_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'b0000, nib};
      if (nib < 4'd10) begin
         return ZERO_CHAR + wide;
      end
      return ALPHA_BIAS + wide;
   endfunction

endpackage

FILE: design/plcfb_front.sv
module plcfb_front #(
   parameter int unsigned ADDRESS_BASE = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic                                  op,
   input  logic [plcfb_pkg::WORD_W-1:0]          word_address,
   input  logic [plcfb_pkg::COUNT_W-1:0]         count,
   input  logic [plcfb_pkg::VALUE_W-1:0]         value,
   output logic                                  cmd_valid,
   input  logic                                  cmd_ready,
   output plcfb_pkg::frame_cmd_type              cmd
);

   logic                     valid_ff, valid_in;
   plcfb_pkg::frame_cmd_type cmd_ff, cmd_in;
   logic                     take;

   assign in_ready  = !valid_ff || cmd_ready;
   assign take      = in_valid && in_ready;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (cmd_ready) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      cmd_in.op        = op;
      // byte address = word * 2 + base, kept to 16 bits
      cmd_in.addr      = {2'b00, word_address, 1'b0} + plcfb_pkg::ADDR_W'(ADDRESS_BASE);
      cmd_in.count     = count;
      cmd_in.value     = value;
      cmd_in.last_step = (op == plcfb_pkg::OP_WRITE) ? plcfb_pkg::WRITE_LAST_STEP
                                                     : plcfb_pkg::READ_LAST_STEP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

FILE: design/plcfb_queue.sv
module plcfb_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  plcfb_pkg::frame_cmd_type      push_cmd,
   input  logic                          pop,
   output plcfb_pkg::frame_cmd_type      head_cmd,
   output plcfb_pkg::queue_status_type   status
);

   plcfb_pkg::frame_cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign status.full  = (fill_ff == 2'd2);
   assign status.empty = (fill_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: design/plcfb_back.sv
module plcfb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  plcfb_pkg::frame_cmd_type      cmd,
   output logic                          cmd_pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [7:0]                    out_byte,
   output logic                          out_last
);

   logic [plcfb_pkg::STEP_W-1:0] step_ff, step_in;
   logic [7:0]                   sum_ff, sum_in;
   logic                         valid_ff, valid_in;
   logic [7:0]                   byte_ff, byte_in;
   logic                         last_ff, last_in;
   logic                         fire;
   logic                         is_sum_char;
   logic                         at_last;

   assign fire      = cmd_valid && (!valid_ff || out_ready);
   assign at_last   = (step_ff == cmd.last_step);
   assign cmd_pop   = fire && at_last;
   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

   // the two checksum characters close the frame
   assign is_sum_char = (step_ff >= cmd.last_step - 4'd1);

   always_comb begin
      byte_in = plcfb_pkg::STX_CHAR;
      case (step_ff)
         4'd0: byte_in = plcfb_pkg::STX_CHAR;
         4'd1: byte_in = (cmd.op == plcfb_pkg::OP_WRITE) ? plcfb_pkg::ONE_CHAR
                                                         : plcfb_pkg::ZERO_CHAR;
         4'd2: byte_in = plcfb_pkg::hex_char(cmd.addr[15:12]);
         4'd3: byte_in = plcfb_pkg::hex_char(cmd.addr[11:8]);
         4'd4: byte_in = plcfb_pkg::hex_char(cmd.addr[7:4]);
         4'd5: byte_in = plcfb_pkg::hex_char(cmd.addr[3:0]);
         4'd6: byte_in = plcfb_pkg::ZERO_CHAR;
         4'd7: byte_in = (cmd.op == plcfb_pkg::OP_WRITE) ? plcfb_pkg::FOUR_CHAR
                         : plcfb_pkg::ZERO_CHAR + {4'b0000, cmd.count};
         4'd8: byte_in = (cmd.op == plcfb_pkg::OP_WRITE)
                         ? plcfb_pkg::hex_char(cmd.value[7:4]) : plcfb_pkg::ETX_CHAR;
         4'd9: byte_in = (cmd.op == plcfb_pkg::OP_WRITE)
                         ? plcfb_pkg::hex_char(cmd.value[3:0])
                         : plcfb_pkg::hex_char(sum_ff[7:4]);
         4'd10: byte_in = (cmd.op == plcfb_pkg::OP_WRITE)
                          ? plcfb_pkg::hex_char(cmd.value[15:12])
                          : plcfb_pkg::hex_char(sum_ff[3:0]);
         4'd11: byte_in = plcfb_pkg::hex_char(cmd.value[11:8]);
         4'd12: byte_in = plcfb_pkg::ETX_CHAR;
         4'd13: byte_in = plcfb_pkg::hex_char(sum_ff[7:4]);
         4'd14: byte_in = plcfb_pkg::hex_char(sum_ff[3:0]);
         default: byte_in = plcfb_pkg::STX_CHAR;
      endcase
   end

   always_comb begin
      last_in  = at_last;
      step_in  = step_ff;
      sum_in   = sum_ff;
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
         step_in  = at_last ? '0 : step_ff + 4'd1;
         // STX is outside the sum, checksum characters too
         if (step_ff == '0) begin
            sum_in = '0;
         end else if (!is_sum_char) begin
            sum_in = sum_ff + byte_in;
         end
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
      sum_ff <= sum_in;
   end

endmodule

FILE: design/plc_serial_frame_builder.sv
// Serial command frame builder: each request word becomes one command frame,
// sent one byte per transfer on the rsp side with tlast on the final checksum
// character. A read frame is 11 bytes, a write frame 15; the byte sequencer
// in the back end emits one byte a cycle while rsp_tready is high and
// requests follow back to back. A front register and a two-deep command
// queue let up to two further requests be taken while a frame is being
// sent. The first byte follows the front register, queue and byte register.
// The address sent is word_address*2 + ADDRESS_BASE, kept to 16 bits.
module plc_serial_frame_builder #(
   parameter int unsigned ADDRESS_BASE = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [12:0] word_address, [16:13] read_byte_count, [32:17] write_value, rest zero
   input  logic [plcfb_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] operation
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] frame_byte
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   logic                          front_valid;
   plcfb_pkg::frame_cmd_type      front_cmd;
   plcfb_pkg::frame_cmd_type      head_cmd;
   plcfb_pkg::queue_status_type   q_status;
   logic                          q_pop;

   plcfb_front #(
      .ADDRESS_BASE (ADDRESS_BASE)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .op           (req_tuser[0]),
      .word_address (req_tdata[12:0]),
      .count        (req_tdata[16:13]),
      .value        (req_tdata[32:17]),
      .cmd_valid    (front_valid),
      .cmd_ready    (!q_status.full),
      .cmd          (front_cmd)
   );

   plcfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   plcfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_status.empty),
      .cmd       (head_cmd),
      .cmd_pop   (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue both full and empty");

   a_last_is_hex: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         (rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39) ||
         (rsp_tdata >= 8'h41 && rsp_tdata <= 8'h46))
      else $error("last byte is not a hex character");

   a_take_loads_front: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> front_valid)
      else $error("accepted request not held in front stage");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule
